// File: hw/rtl/bum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery undervoltage monitor package
// Shared types, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package bum_pkg;

  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned STATE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Full scale in units of 1/256 mV: 36300 * 256.
  localparam int unsigned          SCALE_W    = 24;
  localparam logic [SCALE_W-1:0]   FULL_SCALE = 24'd9292800;

  // Division by ten through a reciprocal: q = (m * RECIP_TEN) >> RECIP_SHIFT.
  localparam int unsigned          DIV_W       = 32;
  localparam logic [DIV_W-1:0]     RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned          RECIP_SHIFT = 35;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_LOWER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHECK_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALARM_COUNT  = 3'd4;

  localparam logic               RST_CHECK_ENABLE = 1'b1;
  localparam logic [VOLT_W-1:0]  RST_WINDOW_UPPER = 16'd11100;
  localparam logic [VOLT_W-1:0]  RST_WINDOW_LOWER = 16'd9000;
  localparam logic [TICK_W-1:0]  RST_CHECK_PERIOD = 16'd200;
  localparam logic [COUNT_W-1:0] RST_ALARM_COUNT  = 8'd10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic               check_enable;
    logic [VOLT_W-1:0]  window_upper_mv;
    logic [VOLT_W-1:0]  window_lower_mv;
    logic [TICK_W-1:0]  check_period_ticks;
    logic [COUNT_W-1:0] alarm_count;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_t;

endpackage

// File: hw/rtl/bum_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample request channel
// Carries one ADC sample per tick with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bum_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: hw/rtl/bum_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result request channel
// Carries the filtered voltage, the alarm pulse and the low counter.
// ----------------------------------------------------------------------------
interface bum_out_if
  import bum_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VOLT_W-1:0]  voltage_mv;
  logic               low_alarm;
  logic [COUNT_W-1:0] low_count;

  modport source (output valid, output voltage_mv, output low_alarm, output low_count,
                  input ready);
  modport sink   (input valid, input voltage_mv, input low_alarm, input low_count,
                  output ready);
endinterface

// File: hw/rtl/battery_undervoltage_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery undervoltage monitor
// Filters periodic ADC samples and raises a pulse on sustained low voltage.
// ----------------------------------------------------------------------------
// Each request on adc_i is one tick carrying the latest ADC code. Each tick
// yields exactly one request on res_o with the filtered voltage in mV, the
// alarm pulse and the low counter, in the order the ticks were taken.
// The block takes one tick per cycle while res_o is not stalled. A tick's
// result passes the input register, which loads at the edge that takes it,
// then four scaler stages, the filter register and the result register.
// The filter register and the check counters close their loops with no
// pipelining inside them, which sets the one-tick rate.
// All stages advance together; when res_o is stalled the whole pipeline
// holds and adc_i.ready falls, and no request is lost.
// Configuration writes through cfg_we_i, cfg_idx_i and cfg_wdata_i take
// effect at once and are meant for an idle block; unknown indexes are
// ignored. Reset clears the filter, the prescaler and the low counter,
// empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_undervoltage_monitor_unit
  import bum_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bum_in_if.sink                adc_i,
  bum_out_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t                   cfg_q;
  logic                   en;
  logic                   in_vld_q;
  logic [SAMPLE_BITS-1:0] code_q;
  logic                   scale_vld, filt_vld, out_vld;
  logic [SCALE_W-1:0]     scaled;
  logic [STATE_W-1:0]     filt;
  pipe_t                  pipe_scale, pipe_filt, pipe_check;

  assign en          = !out_vld || res_o.ready;
  assign adc_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_enable       <= RST_CHECK_ENABLE;
      cfg_q.window_upper_mv    <= RST_WINDOW_UPPER;
      cfg_q.window_lower_mv    <= RST_WINDOW_LOWER;
      cfg_q.check_period_ticks <= RST_CHECK_PERIOD;
      cfg_q.alarm_count        <= RST_ALARM_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_CHECK_ENABLE: cfg_q.check_enable       <= cfg_wdata_i[0];
        CFG_IDX_WINDOW_UPPER: cfg_q.window_upper_mv    <= cfg_wdata_i;
        CFG_IDX_WINDOW_LOWER: cfg_q.window_lower_mv    <= cfg_wdata_i;
        CFG_IDX_CHECK_PERIOD: cfg_q.check_period_ticks <= cfg_wdata_i;
        CFG_IDX_ALARM_COUNT:  cfg_q.alarm_count        <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q <= adc_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && adc_i.valid) begin
      code_q <= adc_i.adc_sample;
    end
  end

  assign pipe_scale = '{en: en, vld: in_vld_q};
  assign pipe_filt  = '{en: en, vld: scale_vld};
  assign pipe_check = '{en: en, vld: filt_vld};

  bum_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pipe_i   (pipe_scale),
    .code_i   (code_q),
    .vld_o    (scale_vld),
    .scaled_o (scaled)
  );

  bum_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pipe_i   (pipe_filt),
    .scaled_i (scaled),
    .vld_o    (filt_vld),
    .filt_o   (filt)
  );

  bum_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_i       (pipe_check),
    .filt_i       (filt),
    .cfg_i        (cfg_q),
    .vld_o        (out_vld),
    .voltage_mv_o (res_o.voltage_mv),
    .low_alarm_o  (res_o.low_alarm),
    .low_count_o  (res_o.low_count)
  );

  assign res_o.valid = out_vld;

endmodule

// File: hw/rtl/bum_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample scaler
// Pipelined conversion of an ADC code to floor(code * FULL_SCALE / (2^n - 1)).
// ----------------------------------------------------------------------------
module bum_scale
  import bum_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pipe_t                  pipe_i,
  input  logic [SAMPLE_BITS-1:0] code_i,
  output logic                   vld_o,
  output logic [SCALE_W-1:0]     scaled_o
);

  localparam int unsigned XW = SAMPLE_BITS + SCALE_W;

  logic [3:0]          vld_q;
  logic [XW-1:0]       x2_q, x3_q, x4_q;
  logic [XW-1:0]       x2_d;
  logic [SCALE_W-1:0]  q3_q, q4_q, a5_q;
  logic [SCALE_W-1:0]  q3_d, q4_d, a5_d;
  logic [XW:0]         sum3, sum4, sum5;
  logic [SCALE_W:0]    hi5, q4_inc;

  // Division by 2^n - 1 as the fixed point of q = (x + q) >> n.
  assign x2_d   = XW'(code_i) * XW'(FULL_SCALE);
  assign sum3   = {1'b0, x2_q} + (XW+1)'(x2_q >> SAMPLE_BITS);
  assign q3_d   = sum3[SAMPLE_BITS +: SCALE_W];
  assign sum4   = {1'b0, x3_q} + (XW+1)'(q3_q);
  assign q4_d   = sum4[SAMPLE_BITS +: SCALE_W];
  assign sum5   = {1'b0, x4_q} + (XW+1)'(q4_q) + (XW+1)'(1);
  assign hi5    = sum5[SAMPLE_BITS +: SCALE_W+1];
  assign q4_inc = {1'b0, q4_q} + (SCALE_W+1)'(1);
  assign a5_d   = (hi5 == q4_inc) ? q4_inc[SCALE_W-1:0] : q4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_i.en) begin
      vld_q <= {vld_q[2:0], pipe_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en) begin
      x2_q <= x2_d;
      x3_q <= x2_q;
      q3_q <= q3_d;
      x4_q <= x3_q;
      q4_q <= q4_d;
      a5_q <= a5_d;
    end
  end

  assign vld_o    = vld_q[3];
  assign scaled_o = a5_q;

endmodule

// File: hw/rtl/bum_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Low-pass filter
// First-order filter F' = round((9 * F + S) / 10) in units of 1/256 mV.
// ----------------------------------------------------------------------------
module bum_filter
  import bum_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_t              pipe_i,
  input  logic [SCALE_W-1:0] scaled_i,
  output logic               vld_o,
  output logic [STATE_W-1:0] filt_o
);

  logic                 vld_q;
  logic [STATE_W-1:0]   filt_q, filt_d;
  logic [DIV_W-1:0]     num;
  logic [2*DIV_W-1:0]   prod;

  assign num    = DIV_W'(filt_q) * DIV_W'(9) + DIV_W'(5) + DIV_W'(scaled_i);
  assign prod   = (2*DIV_W)'(num) * (2*DIV_W)'(RECIP_TEN);
  assign filt_d = prod[RECIP_SHIFT +: STATE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      filt_q <= '0;
    end else if (pipe_i.en) begin
      vld_q <= pipe_i.vld;
      if (pipe_i.vld) begin
        filt_q <= filt_d;
      end
    end
  end

  assign vld_o  = vld_q;
  assign filt_o = filt_q;

endmodule

// File: hw/rtl/bum_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window check and result register
// Prescaler, window test, leaky low counter and the registered result.
// ----------------------------------------------------------------------------
module bum_check
  import bum_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_t              pipe_i,
  input  logic [STATE_W-1:0] filt_i,
  input  cfg_t               cfg_i,
  output logic               vld_o,
  output logic [VOLT_W-1:0]  voltage_mv_o,
  output logic               low_alarm_o,
  output logic [COUNT_W-1:0] low_count_o
);

  logic               vld_q;
  logic [TICK_W-1:0]  tick_q, tick_d, tick_inc;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_upd;
  logic               alarm_d;
  logic               check, in_win;
  logic [VOLT_W-1:0]  volt_q;
  logic               alarm_q;
  logic [COUNT_W-1:0] cnt_out_q;

  always_comb begin
    tick_inc = tick_q + TICK_W'(1);
    check    = (tick_inc >= cfg_i.check_period_ticks);
    in_win   = (filt_i < {cfg_i.window_upper_mv, 8'h00}) &&
               (filt_i > {cfg_i.window_lower_mv, 8'h00});
    tick_d   = tick_inc;
    cnt_d    = cnt_q;
    cnt_upd  = cnt_q;
    alarm_d  = 1'b0;
    if (check) begin
      tick_d = '0;
      if (in_win) begin
        cnt_upd = (cnt_q == COUNT_MAX) ? COUNT_MAX : cnt_q + COUNT_W'(1);
      end else begin
        cnt_upd = cnt_q >> 1;
      end
      cnt_d = cnt_upd;
      if (cnt_upd >= cfg_i.alarm_count) begin
        cnt_d   = '0;
        alarm_d = cfg_i.check_enable;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      tick_q <= '0;
      cnt_q  <= '0;
    end else if (pipe_i.en) begin
      vld_q <= pipe_i.vld;
      if (pipe_i.vld) begin
        tick_q <= tick_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en && pipe_i.vld) begin
      volt_q    <= filt_i[8 +: VOLT_W];
      alarm_q   <= alarm_d;
      cnt_out_q <= cnt_d;
    end
  end

  assign vld_o        = vld_q;
  assign voltage_mv_o = volt_q;
  assign low_alarm_o  = alarm_q;
  assign low_count_o  = cnt_out_q;

endmodule

// File: hw/rtl/bum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery undervoltage monitor checker
// Port-level assertions on the result channel and the input back-pressure.
// ----------------------------------------------------------------------------
module bum_checker
  import bum_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               adc_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [VOLT_W-1:0]  res_voltage_mv_i,
  input logic               res_low_alarm_i,
  input logic [COUNT_W-1:0] res_low_count_i
);

  localparam logic [VOLT_W-1:0] VOLT_MAX = 16'd36300;

  a_alarm_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_low_alarm_i |-> res_low_count_i == '0)
    else $error("alarm shown with a nonzero low count");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !adc_ready_i)
    else $error("sample taken while the result is stalled");

  a_voltage_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_voltage_mv_i <= VOLT_MAX)
    else $error("filtered voltage above full scale");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_voltage_mv_i) &&
    $stable(res_low_alarm_i) && $stable(res_low_count_i))
    else $error("stalled result changed");

endmodule

bind battery_undervoltage_monitor_unit bum_checker u_bum_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .adc_ready_i      (adc_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_voltage_mv_i (res_o.voltage_mv),
  .res_low_alarm_i  (res_o.low_alarm),
  .res_low_count_i  (res_o.low_count)
);
